// ===== src/cmn_pkg.sv =====
// ----------------------------------------------------------------------------
// cmn_pkg
// Shared types and constants of the channel min/max normalizer: request codes,
// field widths, full-scale values and the per-channel mark record.
// ----------------------------------------------------------------------------
package cmn_pkg;

   // field widths
   localparam int REQ_BITS     = 2;
   localparam int CHANNEL_BITS = 4;
   localparam int SAMPLE_BITS  = 10;
   localparam int LEVEL_BITS   = 10;

   // divider step counter width
   localparam int STEP_BITS = $clog2(LEVEL_BITS);

   // full-scale reading and full-scale level
   localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {SAMPLE_BITS{1'b1}};
   localparam logic [LEVEL_BITS-1:0]  LEVEL_MAX  = {LEVEL_BITS{1'b1}};

   // request codes
   typedef enum logic [REQ_BITS-1:0] {
      REQ_CLEAR     = 2'd0,
      REQ_CALIBRATE = 2'd1,
      REQ_NORMALIZE = 2'd2
   } req_code_type;

   // low and high mark of one channel
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] low;
      logic [SAMPLE_BITS-1:0] high;
   } mark_type;

endpackage

// ===== src/cmn_req_if.sv =====
// ----------------------------------------------------------------------------
// cmn_req_if
// Request channel: one beat is a clear, a calibration sample or a normalize
// sample for one channel.
// ----------------------------------------------------------------------------
interface cmn_req_if import cmn_pkg::*; ();

   logic                    valid;
   logic                    ready;
   logic [REQ_BITS-1:0]     req_type;
   logic [CHANNEL_BITS-1:0] channel;
   logic [SAMPLE_BITS-1:0]  sample;

   modport source (output valid, output req_type, output channel, output sample,
                   input ready);
   modport sink   (input valid, input req_type, input channel, input sample,
                   output ready);

endinterface

// ===== src/cmn_rsp_if.sv =====
// ----------------------------------------------------------------------------
// cmn_rsp_if
// Response channel: one beat is the normalized level of one channel.
// ----------------------------------------------------------------------------
interface cmn_rsp_if import cmn_pkg::*; ();

   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] out_channel;
   logic [LEVEL_BITS-1:0]   level;
   logic                    uncalibrated;

   modport source (output valid, output out_channel, output level, output uncalibrated,
                   input ready);
   modport sink   (input valid, input out_channel, input level, input uncalibrated,
                   output ready);

endinterface

// ===== src/channel_minmax_normalizer.sv =====
// ----------------------------------------------------------------------------
// channel_minmax_normalizer
// Per-channel min/max calibration and normalization of multiplexed sensor
// readings, with a bit-serial restoring divider.
// ----------------------------------------------------------------------------
// The block takes one request beat at a time. A clear beat marks every
// channel uncalibrated at once through a valid bit per channel. For a
// calibration beat the mark memory is read at accept and written back the
// cycle after. A normalize beat runs through accept with mark read, lookup,
// range check, ten steps of the restoring divider (one quotient bit per
// cycle), and output load; uncalibrated channels and samples at or below the
// low mark skip the divider, and a quotient too large for the level width
// saturates in the range check. The response sits in an output register, and
// the next request is accepted once the result has moved there.
// ----------------------------------------------------------------------------
module channel_minmax_normalizer
   import cmn_pkg::*;
#(
   parameter int CHANNELS = 16
) (
   input  logic       clock,
   input  logic       reset,
   cmn_req_if.sink    req_bus,
   cmn_rsp_if.source  rsp_bus
);

   localparam int IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_LOOKUP = 5'b00010,
      ST_CHECK  = 5'b00100,
      ST_DIVIDE = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type                 state_ff, state_in;
   logic                      is_cal_ff, is_cal_in;
   logic [CHANNEL_BITS-1:0]   chan_ff, chan_in;
   logic [SAMPLE_BITS-1:0]    sample_ff, sample_in;
   mark_type                  mark_rd_ff;
   logic                      mark_ok_ff;
   logic [CHANNELS-1:0]       mark_vld_ff, mark_vld_in;
   mark_type                  mark_mem [CHANNELS];
   logic [SAMPLE_BITS-1:0]    rem_ff, rem_in;
   logic [LEVEL_BITS-1:0]     quo_ff, quo_in;
   logic [SAMPLE_BITS-1:0]    div_ff, div_in;
   logic [STEP_BITS-1:0]      step_ff, step_in;
   logic                      unc_ff, unc_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CHANNEL_BITS-1:0]   rsp_channel_ff, rsp_channel_in;
   logic [LEVEL_BITS-1:0]     rsp_level_ff, rsp_level_in;
   logic                      rsp_unc_ff, rsp_unc_in;

   logic                      accept;
   logic                      in_range;
   logic                      do_clear;
   logic                      do_start;
   logic [IDX_BITS-1:0]       req_idx;
   logic [IDX_BITS-1:0]       chan_idx;
   logic [SAMPLE_BITS-1:0]    cur_low;
   logic [SAMPLE_BITS-1:0]    cur_high;
   mark_type                  mark_wr;
   logic                      mark_we;
   logic [SAMPLE_BITS-1:0]    diff;
   logic [SAMPLE_BITS+LEVEL_BITS-1:0] numer;
   logic [SAMPLE_BITS:0]      trial;
   logic                      rsp_load;

   // request handshake and decode
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid & req_bus.ready;
   assign in_range      = 32'(req_bus.channel) < CHANNELS;
   assign do_clear      = accept && (req_bus.req_type == REQ_CLEAR);
   assign do_start      = accept && in_range &&
                          ((req_bus.req_type == REQ_CALIBRATE) ||
                           (req_bus.req_type == REQ_NORMALIZE));
   assign req_idx       = IDX_BITS'(req_bus.channel);
   assign chan_idx      = IDX_BITS'(chan_ff);

   // marks of the current channel, reset value when not written since reset or the last clear
   assign cur_low  = mark_ok_ff ? mark_rd_ff.low  : FULL_SCALE;
   assign cur_high = mark_ok_ff ? mark_rd_ff.high : '0;

   // widened marks for a calibration beat
   always_comb begin
      mark_wr.low  = (sample_ff < cur_low)  ? sample_ff : cur_low;
      mark_wr.high = (sample_ff > cur_high) ? sample_ff : cur_high;
   end
   assign mark_we = (state_ff == ST_LOOKUP) && is_cal_ff;

   // numerator (sample - low) * full scale, as shift and subtract
   assign diff  = sample_ff - cur_low;
   assign numer = {diff, {LEVEL_BITS{1'b0}}} -
                  {{LEVEL_BITS{1'b0}}, diff};

   // one restoring divide step
   assign trial = {rem_ff, quo_ff[LEVEL_BITS-1]};

   // response register loads when empty or being drained
   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_bus.ready);

   // next state and datapath
   always_comb begin
      state_in    = state_ff;
      is_cal_in   = is_cal_ff;
      chan_in     = chan_ff;
      sample_in   = sample_ff;
      mark_vld_in = mark_vld_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      div_in      = div_ff;
      step_in     = step_ff;
      unc_in      = unc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (do_clear) begin
               mark_vld_in = '0;
            end
            if (do_start) begin
               is_cal_in = (req_bus.req_type == REQ_CALIBRATE);
               chan_in   = req_bus.channel;
               sample_in = req_bus.sample;
               state_in  = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (is_cal_ff) begin
               mark_vld_in[chan_idx] = 1'b1;
               state_in              = ST_IDLE;
            end else if (cur_high <= cur_low) begin
               unc_in   = 1'b1;
               quo_in   = '0;
               state_in = ST_FINISH;
            end else if (sample_ff <= cur_low) begin
               unc_in   = 1'b0;
               quo_in   = '0;
               state_in = ST_FINISH;
            end else begin
               unc_in   = 1'b0;
               rem_in   = numer[SAMPLE_BITS+LEVEL_BITS-1:LEVEL_BITS];
               quo_in   = numer[LEVEL_BITS-1:0];
               div_in   = cur_high - cur_low;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // quotient would not fit the level width: saturate
            if (rem_ff >= div_ff) begin
               quo_in   = LEVEL_MAX;
               state_in = ST_FINISH;
            end else begin
               step_in  = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (trial >= {1'b0, div_ff}) begin
               rem_in = SAMPLE_BITS'(trial - {1'b0, div_ff});
               quo_in = {quo_ff[LEVEL_BITS-2:0], 1'b1};
            end else begin
               rem_in = trial[SAMPLE_BITS-1:0];
               quo_in = {quo_ff[LEVEL_BITS-2:0], 1'b0};
            end
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(LEVEL_BITS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_channel_in = rsp_channel_ff;
      rsp_level_in   = rsp_level_ff;
      rsp_unc_in     = rsp_unc_ff;
      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_channel_in = chan_ff;
         rsp_level_in   = quo_ff;
         rsp_unc_in     = unc_ff;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.out_channel  = rsp_channel_ff;
   assign rsp_bus.level        = rsp_level_ff;
   assign rsp_bus.uncalibrated = rsp_unc_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mark_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mark_vld_ff  <= mark_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      is_cal_ff      <= is_cal_in;
      chan_ff        <= chan_in;
      sample_ff      <= sample_in;
      rem_ff         <= rem_in;
      quo_ff         <= quo_in;
      div_ff         <= div_in;
      step_ff        <= step_in;
      unc_ff         <= unc_in;
      rsp_channel_ff <= rsp_channel_in;
      rsp_level_ff   <= rsp_level_in;
      rsp_unc_ff     <= rsp_unc_in;
   end

   // mark memory, read at accept and written back after lookup
   always_ff @(posedge clock) begin
      if (do_start) begin
         mark_rd_ff <= mark_mem[req_idx];
         mark_ok_ff <= mark_vld_ff[req_idx];
      end
      if (mark_we) begin
         mark_mem[chan_idx] <= mark_wr;
      end
   end

   // uncalibrated responses carry a zero level
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_unc_ff) |-> (rsp_level_ff == '0))
      else $error("uncalibrated response with nonzero level");

   // divider remainder stays below the divisor
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (rem_ff < div_ff))
      else $error("divider remainder out of range");

   // divider never runs past its last step
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (step_ff < STEP_BITS'(LEVEL_BITS)))
      else $error("divider step count overrun");

   // a clear beat leaves every channel uncalibrated
   assert property (@(posedge clock) disable iff (reset)
      do_clear |=> (mark_vld_ff == '0))
      else $error("clear did not reset the channel marks");

   // a response held back is not overwritten
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |=> (rsp_valid_ff && $stable(rsp_level_ff)))
      else $error("stalled response changed");

endmodule

// ===== sim/cmn_level_checker.sv =====
// ----------------------------------------------------------------------------
// cmn_level_checker
// Watches the request and response channels of the channel min/max
// normalizer. It keeps its own copy of the low and high marks, works out the
// expected level for every normalize beat and compares each response beat
// in order. It hands the mismatch count and the number of levels still
// awaited to the testbench top.
// ----------------------------------------------------------------------------
module cmn_level_checker
   import cmn_pkg::*;
#(
   parameter int CHANNELS = 16
) (
   input  logic clock,
   input  logic reset,
   cmn_req_if   req_mon,
   cmn_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   pending_count
);

   timeunit 1ns;
   timeprecision 1ps;

   // one expected response beat
   typedef struct {
      logic [CHANNEL_BITS-1:0] channel;
      logic [LEVEL_BITS-1:0]   level;
      logic                    uncal;
   } level_beat_type;

   level_beat_type         level_queue[$];
   logic [SAMPLE_BITS-1:0] low_mark_q  [CHANNELS];
   logic [SAMPLE_BITS-1:0] high_mark_q [CHANNELS];

   // expected level of a sample on one channel with the current marks
   function automatic level_beat_type predict_level(input logic [CHANNEL_BITS-1:0] ch,
                                                    input logic [SAMPLE_BITS-1:0]  s);
      level_beat_type beat;
      int unsigned lo, hi, s_val, scaled;
      lo = 32'(low_mark_q[ch]);
      hi = 32'(high_mark_q[ch]);
      s_val = 32'(s);
      beat.channel = ch;
      beat.level   = '0;
      beat.uncal   = 1'b0;
      if (hi <= lo) begin
         beat.uncal = 1'b1;
      end else if (s_val > lo) begin
         scaled = ((s_val - lo) * 32'(LEVEL_MAX)) / (hi - lo);
         beat.level = (scaled > 32'(LEVEL_MAX)) ? LEVEL_MAX : scaled[LEVEL_BITS-1:0];
      end
      return beat;
   endfunction

   // count a failure, print only the first few
   task automatic flag_mismatch(input string detail);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t ns level mismatch: %s", $time, detail);
   endtask

   // response check, then prediction for the request beat of this edge
   always @(posedge clock) begin
      level_beat_type want;
      int             i;
      if (reset) begin
         for (i = 0; i < CHANNELS; i++) begin
            low_mark_q[i]  = FULL_SCALE;
            high_mark_q[i] = '0;
         end
         level_queue.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (level_queue.size() == 0) begin
               flag_mismatch($sformatf("nothing expected, got ch %0d level %0d unc %0b",
                  rsp_mon.out_channel, rsp_mon.level, rsp_mon.uncalibrated));
            end else begin
               want = level_queue.pop_front();
               if (rsp_mon.out_channel !== want.channel || rsp_mon.level !== want.level ||
                   rsp_mon.uncalibrated !== want.uncal)
                  flag_mismatch($sformatf(
                     "expected ch %0d level %0d unc %0b, got ch %0d level %0d unc %0b",
                     want.channel, want.level, want.uncal,
                     rsp_mon.out_channel, rsp_mon.level, rsp_mon.uncalibrated));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            case (req_mon.req_type)
               REQ_CLEAR: begin
                  for (i = 0; i < CHANNELS; i++) begin
                     low_mark_q[i]  = FULL_SCALE;
                     high_mark_q[i] = '0;
                  end
               end
               REQ_CALIBRATE: begin
                  if (32'(req_mon.channel) < CHANNELS) begin
                     if (req_mon.sample < low_mark_q[req_mon.channel])
                        low_mark_q[req_mon.channel] = req_mon.sample;
                     if (req_mon.sample > high_mark_q[req_mon.channel])
                        high_mark_q[req_mon.channel] = req_mon.sample;
                  end
               end
               REQ_NORMALIZE: begin
                  if (32'(req_mon.channel) < CHANNELS)
                     level_queue.push_back(predict_level(req_mon.channel, req_mon.sample));
               end
               default: ;  // unused code, no effect
            endcase
         end
      end
      pending_count = level_queue.size();
   end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench top of the channel min/max normalizer. Drives a directed set of
// clear, calibration and normalize beats, then random calibrate-and-normalize
// sessions with random idling on both channels, a long response hold-off and
// a full drain. The checker beside the block predicts and compares levels.
// ----------------------------------------------------------------------------
module tb;
   import cmn_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int                  CHAN_COUNT      = 16;
   localparam logic [REQ_BITS-1:0] REQ_UNUSED      = 2'd3;
   localparam int                  ITEM_TARGET     = 850;
   localparam int                  QUIET_FROM      = 770;
   localparam int                  HOLD_OFF_CYCLES = 400;
   localparam int                  DRAIN_CYCLES    = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   mismatch_count;
   int   pending_count;
   int   items_sent = 0;
   bit   quiet = 1'b0;
   bit   calm = 1'b0;
   bit   hold_off_start = 1'b0;
   int   win_lo [CHAN_COUNT];
   int   win_hi [CHAN_COUNT];

   cmn_req_if req_bus ();
   cmn_rsp_if rsp_bus ();

   channel_minmax_normalizer #(.CHANNELS(CHAN_COUNT)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   cmn_level_checker #(.CHANNELS(CHAN_COUNT)) level_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard stop
   initial begin
      #5ms;
      $display("channel_minmax_normalizer verification failed");
      $finish;
   end

   // response ready: random stalls, one long hold-off on request
   initial begin
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_start) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_start = 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // random gap after a request beat
   task automatic gap_after_beat();
      if (!quiet && $urandom_range(0, calm ? 15 : 2) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // offer one request beat and wait for it to be taken
   task automatic send_beat(input logic [REQ_BITS-1:0]     kind,
                            input logic [CHANNEL_BITS-1:0] ch,
                            input logic [SAMPLE_BITS-1:0]  s);
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.channel  <= ch;
      req_bus.sample   <= s;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (kind != REQ_UNUSED)
         items_sent++;
      gap_after_beat();
   endtask

   // hold requests until every expected level has come back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      @(posedge clock);
   endtask

   // one calibration session on a few channels, then mixed traffic
   task automatic run_session(input bit start_clear);
      int active[$];
      int n_ch, ch, k, pick, lo_w, hi_w;
      if (start_clear)
         send_beat(REQ_CLEAR, CHANNEL_BITS'($urandom_range(0, 15)),
                   SAMPLE_BITS'($urandom_range(0, 1023)));
      n_ch = $urandom_range(1, 6);
      for (k = 0; k < n_ch; k++) begin
         ch = $urandom_range(0, CHAN_COUNT - 1);
         active.push_back(ch);
         case ($urandom_range(0, 3))
            0: begin
               win_lo[ch] = 0;
               win_hi[ch] = 1023;
            end
            1: begin
               // very narrow range, often a single value
               win_lo[ch] = $urandom_range(0, 1020);
               win_hi[ch] = win_lo[ch] + $urandom_range(0, 3);
            end
            default: begin
               win_lo[ch] = $urandom_range(0, 700);
               win_hi[ch] = win_lo[ch] + $urandom_range(50, 1023 - win_lo[ch]);
            end
         endcase
      end
      // calibration sweep
      repeat ($urandom_range(n_ch * 2, n_ch * 6)) begin
         ch = active[$urandom_range(0, active.size() - 1)];
         send_beat(REQ_CALIBRATE, CHANNEL_BITS'(ch),
                   SAMPLE_BITS'($urandom_range(win_lo[ch], win_hi[ch])));
      end
      // mostly normalize, some late calibration and noise
      repeat ($urandom_range(10, 40)) begin
         pick = $urandom_range(0, 99);
         ch = ($urandom_range(0, 9) != 0) ? active[$urandom_range(0, active.size() - 1)]
                                          : $urandom_range(0, CHAN_COUNT - 1);
         lo_w = (win_lo[ch] > 40) ? win_lo[ch] - 40 : 0;
         hi_w = (win_hi[ch] < 983) ? win_hi[ch] + 40 : 1023;
         if (pick < 65) begin
            if ($urandom_range(0, 3) != 0)
               send_beat(REQ_NORMALIZE, CHANNEL_BITS'(ch),
                         SAMPLE_BITS'($urandom_range(lo_w, hi_w)));
            else
               send_beat(REQ_NORMALIZE, CHANNEL_BITS'(ch),
                         SAMPLE_BITS'($urandom_range(0, 1023)));
         end else if (pick < 90) begin
            send_beat(REQ_CALIBRATE, CHANNEL_BITS'(ch),
                      SAMPLE_BITS'($urandom_range(win_lo[ch], win_hi[ch])));
         end else if (pick < 95) begin
            send_beat(REQ_CALIBRATE, CHANNEL_BITS'($urandom_range(0, 15)),
                      SAMPLE_BITS'($urandom_range(0, 1023)));
         end else begin
            send_beat(REQ_UNUSED, CHANNEL_BITS'($urandom_range(0, 15)),
                      SAMPLE_BITS'($urandom_range(0, 1023)));
         end
      end
   endtask

   // stimulus and verdict
   initial begin
      int session;
      int i;
      req_bus.valid    <= 1'b0;
      req_bus.req_type <= REQ_CLEAR;
      req_bus.channel  <= '0;
      req_bus.sample   <= '0;
      for (i = 0; i < CHAN_COUNT; i++) begin
         win_lo[i] = 0;
         win_hi[i] = 1023;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // marks straight out of reset: uncalibrated
      send_beat(REQ_NORMALIZE, 4'd0, 10'd0);
      send_beat(REQ_UNUSED, 4'd5, 10'd512);
      // range 100..900 on channel 0: below, at low, middle, at high, above high
      send_beat(REQ_CALIBRATE, 4'd0, 10'd100);
      send_beat(REQ_CALIBRATE, 4'd0, 10'd900);
      send_beat(REQ_NORMALIZE, 4'd0, 10'd50);
      send_beat(REQ_NORMALIZE, 4'd0, 10'd100);
      send_beat(REQ_NORMALIZE, 4'd0, 10'd500);
      send_beat(REQ_NORMALIZE, 4'd0, 10'd900);
      send_beat(REQ_NORMALIZE, 4'd0, 10'd1023);
      // full range on channel 15
      send_beat(REQ_CALIBRATE, 4'd15, 10'd0);
      send_beat(REQ_CALIBRATE, 4'd15, 10'd1023);
      send_beat(REQ_NORMALIZE, 4'd15, 10'd1023);
      send_beat(REQ_NORMALIZE, 4'd15, 10'd0);
      send_beat(REQ_NORMALIZE, 4'd15, 10'd1);
      // single-value marks stay uncalibrated
      send_beat(REQ_CALIBRATE, 4'd7, 10'd512);
      send_beat(REQ_NORMALIZE, 4'd7, 10'd512);
      send_beat(REQ_CALIBRATE, 4'd3, 10'd1023);
      send_beat(REQ_NORMALIZE, 4'd3, 10'd1023);
      // range of one step saturates
      send_beat(REQ_CALIBRATE, 4'd1, 10'd1);
      send_beat(REQ_CALIBRATE, 4'd1, 10'd2);
      send_beat(REQ_NORMALIZE, 4'd1, 10'd2);
      send_beat(REQ_NORMALIZE, 4'd1, 10'd1023);
      // clear ignores its channel and sample, then everything is uncalibrated
      send_beat(REQ_CLEAR, 4'd15, 10'd1023);
      send_beat(REQ_NORMALIZE, 4'd0, 10'd500);
      send_beat(REQ_UNUSED, 4'd0, 10'd0);
      wait_drained();

      // random sessions
      session = 0;
      while (items_sent < ITEM_TARGET) begin
         calm  = ~calm;
         quiet = (items_sent >= QUIET_FROM);
         run_session(session == 0 || $urandom_range(0, 2) != 0);
         if (session == 2) begin
            // response side holds off while requests keep coming
            hold_off_start = 1'b1;
            repeat (10)
               send_beat(REQ_NORMALIZE, CHANNEL_BITS'($urandom_range(0, 15)),
                         SAMPLE_BITS'($urandom_range(0, 1023)));
         end
         if (session == 5)
            wait_drained();
         session++;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("channel_minmax_normalizer verification clean");
      else
         $display("channel_minmax_normalizer verification failed");
      $finish;
   end

endmodule

// ===== sim.f =====
src/cmn_pkg.sv
src/cmn_req_if.sv
src/cmn_rsp_if.sv
src/channel_minmax_normalizer.sv
sim/cmn_level_checker.sv
sim/tb.sv
